FILE: sv/qscf_pkg.sv
package qscf_pkg;

  // Sequencer states
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CLEAR = 3'd1;
  localparam logic [2:0] ST_LOOK  = 3'd2;
  localparam logic [2:0] ST_CHECK = 3'd3;
  localparam logic [2:0] ST_MUL   = 3'd4;
  localparam logic [2:0] ST_RED   = 3'd5;
  localparam logic [2:0] ST_OUT   = 3'd6;

  localparam int unsigned COEF_W  = 64;
  localparam int unsigned MOD_W   = 22;
  localparam int unsigned START_W = 21;
  localparam int unsigned INDEX_W = 22;

  // Status codes
  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_BAD_MOD = 1'b1;

endpackage

FILE: sv/quadratic_sequence_cycle_finder_core.sv
// Quadratic sequence cycle finder. A query word carries coefficients a, b, c
// and a modulus m; the block walks s = (a*s*s + b*s + c) mod m (64-bit
// wrapping products) from s = 1 and returns the step index at which the first
// repeated value was first seen and the step at which it repeated. A modulus
// of zero or above 2^STATE_BITS gives status 1 with zero indexes, valid the
// cycle after the query is taken. Otherwise a query first clears max(m,2)
// entries of the visit memory, one per cycle. Each step then takes a memory
// lookup, three 64-bit multiplies that share one 32x32 multiplier (three
// partial products each, one per cycle) and a restoring shift-subtract
// modulo of the 64-bit sum, one bit per cycle. The repeat is found after
// one more memory lookup.
// The block is not ready while a query is under way; one result is held in an
// output register until taken.
module quadratic_sequence_cycle_finder_core #(
  parameter int unsigned STATE_BITS = 21
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // coef_square[63:0], coef_linear[127:64], coef_const[191:128], modulus[213:192], pad
  input  logic [215:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // cycle_start[20:0], repeat_index[42:21], status[43], pad
  output logic [47:0]  out_tdata
);

  localparam int unsigned DEPTH = 1 << STATE_BITS;
  localparam int unsigned SW    = STATE_BITS;
  localparam int unsigned CW    = qscf_pkg::COEF_W;

  logic [2:0] state_r, state_nxt;

  logic [CW-1:0] a_r, b_r, c_r;
  logic [SW:0]   m_r;
  logic [SW-1:0] s_r;
  logic [qscf_pkg::INDEX_W-1:0] step_r;
  logic [SW:0]   clr_r;

  // visit memory: step index + 1, zero means unvisited
  logic [qscf_pkg::INDEX_W-1:0] vmem [DEPTH];
  logic [qscf_pkg::INDEX_W-1:0] rd_r;

  // multiply sequencer
  logic [1:0]    op_r;     // 0: s*s, 1: ss*a, 2: s*b
  logic [1:0]    pp_r;     // partial product select
  logic [CW-1:0] acc_r, ss_r, sum_r;
  logic [CW-1:0] rem_r;
  logic [6:0]    bit_r;

  logic [qscf_pkg::START_W-1:0] res_start_r;
  logic [qscf_pkg::INDEX_W-1:0] res_rep_r;
  logic                         res_stat_r;

  logic [qscf_pkg::MOD_W-1:0] in_mod;
  assign in_mod = in_tdata[213:192];

  assign in_tready  = (state_r == qscf_pkg::ST_IDLE);
  assign out_tvalid = (state_r == qscf_pkg::ST_OUT);
  assign out_tdata  = {4'd0, res_stat_r, res_rep_r, res_start_r};

  // operands of the current multiply
  logic [CW-1:0] mx, my;
  always_comb begin
    unique case (op_r)
      2'd0:    begin mx = {{(CW-SW){1'b0}}, s_r}; my = {{(CW-SW){1'b0}}, s_r}; end
      2'd1:    begin mx = ss_r; my = a_r; end
      default: begin mx = {{(CW-SW){1'b0}}, s_r}; my = b_r; end
    endcase
  end

  // one 32x32 partial product per cycle; only low 64 bits are kept
  logic [31:0] px, py;
  logic [63:0] pprod, pshift;
  always_comb begin
    unique case (pp_r)
      2'd0:    begin px = mx[31:0];  py = my[31:0];  end
      2'd1:    begin px = mx[63:32]; py = my[31:0];  end
      2'd2:    begin px = mx[31:0];  py = my[63:32]; end
      default: begin px = 32'd0;     py = 32'd0;     end
    endcase
    pprod  = {32'd0, px} * {32'd0, py};
    pshift = (pp_r == 2'd0) ? pprod : {pprod[31:0], 32'd0};
  end

  // restoring modulo step
  logic [CW:0] rtrial;
  logic [CW:0] rshift;
  logic [CW-1:0] sbit;
  always_comb begin
    sbit   = sum_r >> bit_r[5:0];
    rshift = {rem_r, sbit[0]};
    rtrial = rshift - {{(CW+1-SW-1){1'b0}}, m_r};
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      qscf_pkg::ST_IDLE:  if (in_tvalid) begin
        if (in_mod == '0 || 32'(in_mod) > DEPTH)
          state_nxt = qscf_pkg::ST_OUT;
        else
          state_nxt = qscf_pkg::ST_CLEAR;
      end
      qscf_pkg::ST_CLEAR: if (clr_r == '0) state_nxt = qscf_pkg::ST_LOOK;
      qscf_pkg::ST_LOOK:  state_nxt = qscf_pkg::ST_CHECK;
      qscf_pkg::ST_CHECK: state_nxt = (rd_r != '0) ? qscf_pkg::ST_OUT : qscf_pkg::ST_MUL;
      qscf_pkg::ST_MUL:   if (pp_r == 2'd2 && op_r == 2'd2) state_nxt = qscf_pkg::ST_RED;
      qscf_pkg::ST_RED:   if (bit_r == 7'd0) state_nxt = qscf_pkg::ST_LOOK;
      qscf_pkg::ST_OUT:   if (out_tready) state_nxt = qscf_pkg::ST_IDLE;
      default:            state_nxt = qscf_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= qscf_pkg::ST_IDLE;
    else        state_r <= state_nxt;
  end

  // memory port: one write, one registered read
  always_ff @(posedge clk) begin
    if (state_r == qscf_pkg::ST_CLEAR)
      vmem[clr_r[SW-1:0]] <= '0;
    else if (state_r == qscf_pkg::ST_CHECK && rd_r == '0)
      vmem[s_r] <= step_r + 1'b1;
    rd_r <= vmem[s_r];
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state_r)
      qscf_pkg::ST_IDLE: if (in_tvalid) begin
        a_r <= in_tdata[63:0];
        b_r <= in_tdata[127:64];
        c_r <= in_tdata[191:128];
        m_r <= (SW+1)'(in_mod);
        s_r <= SW'(1);
        step_r <= '0;
        clr_r <= (in_mod < 2) ? (SW+1)'(1) : (SW+1)'(in_mod) - 1'b1;
        res_start_r <= '0;
        res_rep_r   <= '0;
        res_stat_r  <= qscf_pkg::STATUS_BAD_MOD;
      end
      qscf_pkg::ST_CLEAR: clr_r <= clr_r - 1'b1;
      qscf_pkg::ST_CHECK: begin
        if (rd_r != '0) begin
          res_start_r <= qscf_pkg::START_W'(rd_r - 1'b1);
          res_rep_r   <= step_r;
          res_stat_r  <= qscf_pkg::STATUS_OK;
        end else begin
          op_r  <= 2'd0;
          pp_r  <= 2'd0;
          acc_r <= '0;
          sum_r <= c_r;
        end
      end
      qscf_pkg::ST_MUL: begin
        if (pp_r == 2'd2) begin
          pp_r  <= 2'd0;
          acc_r <= '0;
          if (op_r == 2'd0) ss_r <= acc_r + pshift;
          else sum_r <= sum_r + acc_r + pshift;
          op_r  <= op_r + 1'b1;
          rem_r <= '0;
          bit_r <= 7'd63;
        end else begin
          pp_r  <= pp_r + 1'b1;
          acc_r <= acc_r + pshift;
        end
      end
      qscf_pkg::ST_RED: begin
        rem_r <= rtrial[CW] ? rshift[CW-1:0] : rtrial[CW-1:0];
        bit_r <= bit_r - 1'b1;
        if (bit_r == 7'd0) begin
          s_r    <= rtrial[CW] ? rshift[SW-1:0] : rtrial[SW-1:0];
          step_r <= step_r + 1'b1;
        end
      end
      default: ;
    endcase
  end

endmodule
